// File: src/pt4_pkg.sv
// ----------------------------------------------------------------------------
// pt4_pkg
// Shared types and constants of the 4x4 homogeneous point transform.
// ----------------------------------------------------------------------------
package pt4_pkg;

  // Opcodes
  localparam logic OP_POINT = 1'b0;
  localparam logic OP_DIR   = 1'b1;

  // Register map, index is paddr[4:3]
  localparam logic [1:0] REG_ROW_ZERO  = 2'd0;
  localparam logic [1:0] REG_ROW_ONE   = 2'd1;
  localparam logic [1:0] REG_ROW_TWO   = 2'd2;
  localparam logic [1:0] REG_ROW_THREE = 2'd3;

  // Reset matrix is the identity in Q8.8
  localparam logic [63:0] ROW_ZERO_RST  = 64'h0000_0000_0000_0100;
  localparam logic [63:0] ROW_ONE_RST   = 64'h0000_0000_0100_0000;
  localparam logic [63:0] ROW_TWO_RST   = 64'h0000_0100_0000_0000;
  localparam logic [63:0] ROW_THREE_RST = 64'h0100_0000_0000_0000;

  localparam int unsigned LANE_W = 16;

  // Control that travels with each item through the output pipeline
  typedef struct packed {
    logic valid;
    logic point;
    logic w_zero;
  } ctrl_t;

endpackage

// File: src/pt4_regs.sv
// ----------------------------------------------------------------------------
// pt4_regs
// Matrix row registers behind an APB-style port, 64-bit data.
// ----------------------------------------------------------------------------
module pt4_regs import pt4_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output logic [3:0][63:0] rows_o
);

  logic [3:0][63:0] rows_q;
  logic             wr_en;
  logic [1:0]       idx;

  assign idx    = paddr[4:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = rows_q[idx];
  assign rows_o = rows_q;

  // Write one row per completed access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[REG_ROW_ZERO]  <= ROW_ZERO_RST;
      rows_q[REG_ROW_ONE]   <= ROW_ONE_RST;
      rows_q[REG_ROW_TWO]   <= ROW_TWO_RST;
      rows_q[REG_ROW_THREE] <= ROW_THREE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ROW_ZERO:  rows_q[REG_ROW_ZERO]  <= pwdata;
        REG_ROW_ONE:   rows_q[REG_ROW_ONE]   <= pwdata;
        REG_ROW_TWO:   rows_q[REG_ROW_TWO]   <= pwdata;
        REG_ROW_THREE: rows_q[REG_ROW_THREE] <= pwdata;
        default: ;
      endcase
    end
  end

endmodule

// File: src/pt4_mac.sv
// ----------------------------------------------------------------------------
// pt4_mac
// One matrix column: x*c0 + y*c1 + z*c2 (+ aligned translation), 3 stages.
// ----------------------------------------------------------------------------
module pt4_mac import pt4_pkg::*; #(
  parameter int unsigned CW = 32,
  parameter int unsigned KW = 16,
  localparam int unsigned PW = CW + KW + 2,
  localparam int unsigned CF = CW / 2
) (
  input  logic                 clk_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  input  logic signed [KW-1:0] c0_i,
  input  logic signed [KW-1:0] c1_i,
  input  logic signed [KW-1:0] c2_i,
  input  logic signed [KW-1:0] t_i,
  input  logic                 use_t_i,
  output logic signed [PW-1:0] sum_o
);

  logic signed [CW+KW-1:0] p0_q, p1_q, p2_q;
  logic signed [PW-1:0]    t_d, t_q, s01_q, s2t_q, sum_q;

  // Align translation to the product format
  assign t_d = use_t_i ? {{(PW-KW-CF){t_i[KW-1]}}, t_i, {CF{1'b0}}} : '0;

  // Multiply
  always_ff @(posedge clk_i) begin
    p0_q <= x_i * c0_i;
    p1_q <= y_i * c1_i;
    p2_q <= z_i * c2_i;
    t_q  <= t_d;
  end

  // Add pairs, then the final sum
  always_ff @(posedge clk_i) begin
    s01_q <= PW'(p0_q) + PW'(p1_q);
    s2t_q <= PW'(p2_q) + t_q;
    sum_q <= s01_q + s2t_q;
  end

  assign sum_o = sum_q;

endmodule

// File: src/pt4_div.sv
// ----------------------------------------------------------------------------
// pt4_div
// One output component: direction shift and clamp, or pipelined restoring
// division by w with one quotient bit per stage, then sign and clamp.
// ----------------------------------------------------------------------------
module pt4_div import pt4_pkg::*; #(
  parameter int unsigned CW = 32,
  parameter int unsigned KW = 16,
  localparam int unsigned PW = CW + KW + 2,
  localparam int unsigned CF = CW / 2,
  localparam int unsigned KF = KW / 2,
  localparam int unsigned SH = CW - CF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  input  logic signed [PW-1:0] p_i,
  input  logic signed [PW-1:0] w_i,
  output ctrl_t                ctrl_o,
  output logic        [CW-1:0] out_o,
  output logic                 sat_o
);

  localparam logic [CW-1:0] MAX_V = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MIN_V = {1'b1, {(CW-1){1'b0}}};

  // Stage 0: magnitudes, direction result
  logic signed [PW-1:0] dsh;
  logic                 dfit;
  ctrl_t                c0_q;
  logic [PW-1:0]        pmag0_q, dmag0_q;
  logic                 qneg0_q, dsat0_q;
  logic [CW-1:0]        dval0_q;

  assign dsh  = p_i >>> KF;
  assign dfit = (&dsh[PW-1:CW-1]) | ~(|dsh[PW-1:CW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
    end else begin
      c0_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pmag0_q <= p_i[PW-1] ? PW'(-p_i) : PW'(p_i);
    dmag0_q <= w_i[PW-1] ? PW'(-w_i) : PW'(w_i);
    qneg0_q <= p_i[PW-1] ^ w_i[PW-1];
    dsat0_q <= ~dfit;
    dval0_q <= dfit ? dsh[CW-1:0] : (dsh[PW-1] ? MIN_V : MAX_V);
  end

  // Stage array: index 0 holds the overflow check and first remainder
  ctrl_t         c_q    [0:CW];
  logic [PW-1:0] rem_q  [0:CW];
  logic [PW-1:0] dm_q   [0:CW];
  logic [CW-1:0] nl_q   [0:CW];
  logic [CW-1:0] q_q    [0:CW];
  logic          ovf_q  [0:CW];
  logic          qneg_q [0:CW];
  logic          dsat_q [0:CW];
  logic [CW-1:0] dval_q [0:CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q[0] <= '0;
    end else begin
      c_q[0] <= c0_q;
    end
  end

  // Quotient overflows CW bits when |p| * 2^CF >= |w| * 2^CW
  always_ff @(posedge clk_i) begin
    ovf_q[0]  <= (PW+CW)'({pmag0_q, {CF{1'b0}}}) >= {dmag0_q, {CW{1'b0}}};
    rem_q[0]  <= pmag0_q >> SH;
    nl_q[0]   <= {pmag0_q[SH-1:0], {CF{1'b0}}};
    q_q[0]    <= '0;
    dm_q[0]   <= dmag0_q;
    qneg_q[0] <= qneg0_q;
    dsat_q[0] <= dsat0_q;
    dval_q[0] <= dval0_q;
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= CW; k++) begin : g_stage
    logic [PW:0] trial;
    logic        ge;

    assign trial = {rem_q[k-1], nl_q[k-1][CW-1]};
    assign ge    = trial >= {1'b0, dm_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_q[k] <= '0;
      end else begin
        c_q[k] <= c_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? PW'(trial - {1'b0, dm_q[k-1]}) : trial[PW-1:0];
      nl_q[k]   <= {nl_q[k-1][CW-2:0], 1'b0};
      q_q[k]    <= {q_q[k-1][CW-2:0], ge};
      dm_q[k]   <= dm_q[k-1];
      ovf_q[k]  <= ovf_q[k-1];
      qneg_q[k] <= qneg_q[k-1];
      dsat_q[k] <= dsat_q[k-1];
      dval_q[k] <= dval_q[k-1];
    end
  end

  // Final select: mode, zero w, sign and clamp
  ctrl_t         cf_q;
  logic [CW-1:0] out_d, out_q;
  logic          sat_d, sat_q;
  logic [CW-1:0] qf;

  assign qf = q_q[CW];

  always_comb begin
    out_d = '0;
    sat_d = 1'b0;
    if (!c_q[CW].point) begin
      out_d = dval_q[CW];
      sat_d = dsat_q[CW];
    end else if (c_q[CW].w_zero) begin
      out_d = '0;
      sat_d = 1'b0;
    end else if (ovf_q[CW]) begin
      out_d = qneg_q[CW] ? MIN_V : MAX_V;
      sat_d = 1'b1;
    end else if (qneg_q[CW]) begin
      if (qf[CW-1] & (|qf[CW-2:0])) begin
        out_d = MIN_V;
        sat_d = 1'b1;
      end else begin
        out_d = CW'(-qf);
      end
    end else if (qf[CW-1]) begin
      out_d = MAX_V;
      sat_d = 1'b1;
    end else begin
      out_d = qf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_q <= '0;
    end else begin
      cf_q <= c_q[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sat_q <= sat_d;
  end

  assign ctrl_o = cf_q;
  assign out_o  = out_q;
  assign sat_o  = sat_q;

endmodule

// File: src/point_transform_4x4.sv
// ----------------------------------------------------------------------------
// point_transform_4x4
// Throughput: one item per cycle; busy_o stays low. Most of the depth comes
// from the divider array, one quotient bit per stage, one array per component.
// Reset clears all valid bits and loads the identity matrix.
// The receiver cannot stall: done_o marks each result for one cycle.
// ----------------------------------------------------------------------------
module point_transform_4x4 import pt4_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COEF_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          opcode_i,
  input  logic signed [COORD_WIDTH-1:0] in_x_i,
  input  logic signed [COORD_WIDTH-1:0] in_y_i,
  input  logic signed [COORD_WIDTH-1:0] in_z_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic                          w_zero_o,
  output logic                          saturated_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned KW = COEF_WIDTH;
  localparam int unsigned PW = CW + KW + 2;

  logic [3:0][63:0]     rows;
  logic                 point;
  logic signed [PW-1:0] sum [0:3];

  assign busy_o = 1'b0;
  assign point  = (opcode_i == OP_POINT);

  pt4_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows_o  (rows)
  );

  // One dot product per matrix column; column 3 gives w
  for (genvar j = 0; j < 4; j++) begin : g_col
    pt4_mac #(.CW(CW), .KW(KW)) u_mac (
      .clk_i   (clk_i),
      .x_i     (in_x_i),
      .y_i     (in_y_i),
      .z_i     (in_z_i),
      .c0_i    (rows[REG_ROW_ZERO][LANE_W*j +: KW]),
      .c1_i    (rows[REG_ROW_ONE][LANE_W*j +: KW]),
      .c2_i    (rows[REG_ROW_TWO][LANE_W*j +: KW]),
      .t_i     (rows[REG_ROW_THREE][LANE_W*j +: KW]),
      .use_t_i (point),
      .sum_o   (sum[j])
    );
  end

  // Carry valid and mode alongside the multiply-add stages
  logic [2:0] vld_q, pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      pt_q  <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i & ~busy_o};
      pt_q  <= {pt_q[1:0], point};
    end
  end

  ctrl_t ctrl_in;
  ctrl_t ctrl_out [0:2];
  logic  [CW-1:0] res [0:2];
  logic  [2:0]    sat;

  always_comb begin
    ctrl_in.valid  = vld_q[2];
    ctrl_in.point  = pt_q[2];
    ctrl_in.w_zero = pt_q[2] & (sum[3] == '0);
  end

  // Divide and clamp each component
  for (genvar j = 0; j < 3; j++) begin : g_out
    pt4_div #(.CW(CW), .KW(KW)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_in),
      .p_i    (sum[j]),
      .w_i    (sum[3]),
      .ctrl_o (ctrl_out[j]),
      .out_o  (res[j]),
      .sat_o  (sat[j])
    );
  end

  assign done_o      = ctrl_out[0].valid;
  assign w_zero_o    = ctrl_out[0].w_zero;
  assign out_x_o     = res[0];
  assign out_y_o     = res[1];
  assign out_z_o     = res[2];
  assign saturated_o = |sat;

endmodule

// File: bench/point_transform_4x4_test.sv
// ----------------------------------------------------------------------------
// point_transform_4x4_test
// Self-checking bench for the 4x4 homogeneous point transform. An initial
// block loads matrices over APB and queues vectors; a clocked driver issues
// them with random gaps, save for one stretch without, and a clocked monitor
// checks every result against a fixed point predictor of the transform.
// ----------------------------------------------------------------------------
module point_transform_4x4_test;
  import pt4_pkg::*;

  typedef struct {
    logic               op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_item_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        w_zero;
    logic        sat;
  } vec_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               opcode_i = OP_POINT;
  logic signed [31:0] in_x_i = '0;
  logic signed [31:0] in_y_i = '0;
  logic signed [31:0] in_z_i = '0;
  logic               done_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic               w_zero_o;
  logic               saturated_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  vec_item_t   pending_items[$];
  vec_result_t expected_results[$];
  logic [63:0] matrix[4];
  vec_item_t   cur_item;
  int          gap_left = 0;
  bit          gaps_on = 1'b1;
  int          mismatches = 0;
  int          cycles = 0;

  point_transform_4x4 uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Signed Q8.8 coefficient of row r, column c
  function automatic longint coef(int r, int c);
    return longint'($signed(matrix[r][c*16 +: 16]));
  endfunction

  // Clamp to 32 bits, flag on clamp
  function automatic logic [31:0] clamp32(logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Expected result of one vector under the current matrix
  function automatic vec_result_t transform_vector(vec_item_t it);
    vec_result_t r;
    longint acc[4];
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic [31:0] o[3];
    logic sat;
    logic point;
    sat = 1'b0;
    point = (it.op == OP_POINT);
    for (int c = 0; c < 4; c++) begin
      acc[c] = longint'(it.x) * coef(0, c) + longint'(it.y) * coef(1, c)
             + longint'(it.z) * coef(2, c);
      if (point) acc[c] += coef(3, c) <<< 16;
    end
    r.w_zero = 1'b0;
    if (point && acc[3] == 0) begin
      foreach (o[c]) o[c] = '0;
      r.w_zero = 1'b1;
    end else begin
      for (int c = 0; c < 3; c++) begin
        num = acc[c];
        if (point) begin
          num = num <<< 16;
          den = acc[3];
          o[c] = clamp32(num / den, sat);
        end else begin
          o[c] = clamp32(num >>> 8, sat);
        end
      end
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Random coordinate: full range, small values or extremes
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3, 4: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_row();
    logic [63:0] row;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(0, 5))
        0: row[c*16 +: 16] = 16'h7fff;
        1: row[c*16 +: 16] = 16'h8000;
        2: row[c*16 +: 16] = '0;
        3: row[c*16 +: 16] = 16'($urandom_range(0, 1023)) - 16'd512;
        default: row[c*16 +: 16] = 16'($urandom);
      endcase
    end
    return row;
  endfunction

  task automatic queue_vec(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vec_item_t it;
    it.op = op;
    it.x = x;
    it.y = y;
    it.z = z;
    pending_items.push_back(it);
  endtask

  // Two-phase APB write, mirrored into the predictor
  task automatic write_row(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    matrix[idx] = val;
  endtask

  // Wait until every queued item has gone through and the pipe has drained
  task automatic drain();
    while (pending_items.size() != 0 || start_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      queue_vec(1'($urandom), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Driver: issue items, record expectation at acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && busy_o) begin
      // hold the item until accepted
    end else begin
      if (start_i) expected_results.push_back(transform_vector(cur_item));
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        start_i <= 1'b1;
        opcode_i <= cur_item.op;
        in_x_i <= cur_item.x;
        in_y_i <= cur_item.y;
        in_z_i <= cur_item.z;
        if (gaps_on) begin
          case ($urandom_range(0, 19))
            0: gap_left = $urandom_range(8, 30);
            1, 2, 3, 4: gap_left = $urandom_range(1, 3);
            default: gap_left = 0;
          endcase
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest expectation
  always @(posedge clk_i) begin
    vec_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected done", 32'(done_o), 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_x_o !== want.x) report_mismatch("out_x", out_x_o, want.x);
        if (out_y_o !== want.y) report_mismatch("out_y", out_y_o, want.y);
        if (out_z_o !== want.z) report_mismatch("out_z", out_z_o, want.z);
        if (w_zero_o !== want.w_zero)
          report_mismatch("w_zero", 32'(w_zero_o), 32'(want.w_zero));
        if (saturated_o !== want.sat)
          report_mismatch("saturated", 32'(saturated_o), 32'(want.sat));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 300000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    matrix[0] = ROW_ZERO_RST;
    matrix[1] = ROW_ONE_RST;
    matrix[2] = ROW_TWO_RST;
    matrix[3] = ROW_THREE_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity matrix: extremes and both opcodes
    queue_vec(OP_POINT, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000);
    queue_vec(OP_DIR, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000);
    queue_vec(OP_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    queue_vec(OP_DIR, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    queue_vec(OP_POINT, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
    queue_vec(OP_DIR, 32'h0, 32'h0, 32'h0);
    drain();

    // Large coefficients: saturation both ways
    write_row(REG_ROW_ZERO, 64'h0100_7fff_8000_7fff);
    write_row(REG_ROW_ONE, 64'h0000_8000_7fff_0100);
    write_row(REG_ROW_TWO, 64'h0000_0100_0100_8000);
    write_row(REG_ROW_THREE, 64'h0001_7fff_8000_7fff);
    queue_vec(OP_DIR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_vec(OP_DIR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vec(OP_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    queue_vec(OP_POINT, 32'h0000_0001, 32'h0, 32'h0);
    queue_vec(OP_POINT, 32'h0, 32'h0, 32'h0);
    drain();

    // w column all zero: every point meets zero w
    write_row(REG_ROW_ZERO, 64'h0000_1234_8000_7fff);
    write_row(REG_ROW_ONE, 64'h0000_0100_0100_0100);
    write_row(REG_ROW_TWO, 64'h0000_ffff_0001_8000);
    write_row(REG_ROW_THREE, 64'h0000_7fff_0100_8000);
    queue_vec(OP_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
    queue_vec(OP_DIR, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
    queue_random(60);
    drain();

    // Random matrices, one stretch without gaps
    for (int p = 0; p < 12; p++) begin
      gaps_on = (p != 3);
      for (int r = 0; r < 4; r++) write_row(2'(r), rand_row());
      // keep w often nonzero and moderate
      if (p % 2 == 0) write_row(REG_ROW_THREE, {16'($urandom_range(64, 1024)), 48'($urandom)});
      queue_random(100);
      drain();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
